[sv/mwie_pkg.sv]
// ----------------------------------------------------------------------------
// mwie_pkg
// Shared types and constants for the mnemonic word index encoder.
// ----------------------------------------------------------------------------
package mwie_pkg;

	localparam int CHUNK_W    = 32;              // seed chunk width
	localparam int LEN_W      = 17;              // word list length register
	localparam int WPC_W      = 4;               // words per chunk register
	localparam int IDX_W      = 16;              // word index width
	localparam int MAX_WORDS  = 8;
	localparam int WORD_W     = $clog2(MAX_WORDS);
	localparam int BITS_STEP  = 2;               // quotient bits per divide cycle
	localparam int DIV_STEPS  = CHUNK_W / BITS_STEP;
	localparam int STEP_W     = $clog2(DIV_STEPS);
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1626);
	localparam logic [WPC_W-1:0] WPC_RESET = WPC_W'(3);

	// register index, taken from paddr[2]
	localparam logic REG_LEN = 1'b0;
	localparam logic REG_WPC = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	typedef struct packed {
		logic load;        // take a new chunk
		logic step;        // one radix-4 divide cycle
		logic emit;        // form and present one index
		logic final_word;  // emitted index closes the chunk
	} dp_cmd_t;

endpackage

[sv/mnemonic_word_index_encoder.sv]
// ----------------------------------------------------------------------------
// mnemonic_word_index_encoder
// Turns 32-bit seed chunks into word-list indices, one to eight per chunk.
// Usage
//   Input: a chunk is taken at the clock edge where start is high and busy
//   low. chunk_word holds four seed bytes assembled little-endian,
//   last_chunk flags the final chunk of the seed.
//   Output: each index beat is shown for exactly one cycle with valid high;
//   the receiver cannot stall. last_of_chunk marks the final index of a
//   chunk, last_of_input the final index of the final chunk.
//   Config: APB, list length at 0x0, word count at 0x4. Write only while
//   busy is low and no result is pending.
// Sequence
//   Each word is divided by the list length, two quotient bits a cycle,
//   then emitted; the index beat is registered from the emit state. busy
//   stays high until the final word of the chunk is emitted, so a new chunk
//   is not taken before the last one is through.
// Reset: clears the sequencer and valid, loads length 1626 and three words.
// ----------------------------------------------------------------------------
module mnemonic_word_index_encoder
	import mwie_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               start,
	output logic               busy,
	input  logic [CHUNK_W-1:0] chunk_word,
	input  logic               last_chunk,
	// result beats
	output logic               valid,
	output logic [IDX_W-1:0]   word_index,
	output logic               last_of_chunk,
	output logic               last_of_input,
	// APB configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	logic [LEN_W-1:0] list_len;
	logic [WPC_W-1:0] chunk_words;
	dp_cmd_t          cmd;

	mwie_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.list_len    (list_len),
		.chunk_words (chunk_words)
	);

	// sequencer: counts divide cycles and words, drives the datapath
	mwie_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.chunk_words (chunk_words),
		.busy        (busy),
		.cmd         (cmd)
	);

	// divider, index adder and registered result beat
	mwie_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.chunk_word    (chunk_word),
		.last_chunk    (last_chunk),
		.list_len      (list_len),
		.word_index    (word_index),
		.last_of_chunk (last_of_chunk),
		.last_of_input (last_of_input),
		.valid         (valid)
	);

endmodule

[sv/mwie_regs.sv]
// ----------------------------------------------------------------------------
// mwie_regs
// APB configuration registers: word list length and words per chunk.
// ----------------------------------------------------------------------------
module mwie_regs
	import mwie_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic [LEN_W-1:0]  list_len,
	output logic [WPC_W-1:0]  chunk_words
);

	logic [LEN_W-1:0] len_q;
	logic [WPC_W-1:0] wpc_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
			wpc_q <= WPC_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_LEN: len_q <= pwdata[LEN_W-1:0];
				REG_WPC: wpc_q <= pwdata[WPC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_LEN: prdata = DATA_W'(len_q);
			REG_WPC: prdata = DATA_W'(wpc_q);
			default: prdata = '0;
		endcase
	end

	assign list_len    = len_q;
	assign chunk_words = wpc_q;

endmodule

[sv/mwie_ctrl.sv]
// ----------------------------------------------------------------------------
// mwie_ctrl
// Sequencer: divide cycles, then an emit cycle, for each word of a chunk.
// ----------------------------------------------------------------------------
module mwie_ctrl
	import mwie_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WPC_W-1:0] chunk_words,
	output logic             busy,
	output dp_cmd_t          cmd
);

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] last_word_q;
	logic [WORD_W-1:0] count_m1;
	logic              final_word;

	// zero words means one, more than the maximum is clipped
	always_comb begin
		if (chunk_words == '0)
			count_m1 = '0;
		else if (chunk_words > WPC_W'(MAX_WORDS))
			count_m1 = WORD_W'(MAX_WORDS - 1);
		else
			count_m1 = WORD_W'(chunk_words - WPC_W'(1));
	end

	assign final_word = (word_q == last_word_q);
	assign busy       = (state_q != ST_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == ST_IDLE) && start;
		cmd.step       = (state_q == ST_DIV);
		cmd.emit       = (state_q == ST_EMIT);
		cmd.final_word = final_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			word_q      <= '0;
			last_word_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						step_q      <= '0;
						word_q      <= '0;
						last_word_q <= count_m1;
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_STEPS - 1))
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					step_q <= '0;
					if (final_word) begin
						state_q <= ST_IDLE;
					end else begin
						word_q  <= word_q + WORD_W'(1);
						state_q <= ST_DIV;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[sv/mwie_dp.sv]
// ----------------------------------------------------------------------------
// mwie_dp
// Datapath: radix-4 restoring divider by the list length, index adder and
// result register.
// ----------------------------------------------------------------------------
module mwie_dp
	import mwie_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	input  logic [CHUNK_W-1:0] chunk_word,
	input  logic               last_chunk,
	input  logic [LEN_W-1:0]   list_len,
	output logic [IDX_W-1:0]   word_index,
	output logic               last_of_chunk,
	output logic               last_of_input,
	output logic               valid
);

	logic [CHUNK_W-1:0] quo_q;   // dividend shifting out, quotient shifting in
	logic [LEN_W-1:0]   rem_q;
	logic [IDX_W-1:0]   prev_q;
	logic [LEN_W-1:0]   len_q;
	logic               last_q;

	logic [IDX_W-1:0]   word_index_q;
	logic               last_of_chunk_q;
	logic               last_of_input_q;
	logic               valid_q;

	logic [LEN_W:0]     r1, r2;
	logic               ge1, ge2;
	logic [LEN_W-1:0]   r1s, r2s;
	logic [LEN_W:0]     sum;
	logic [LEN_W-1:0]   idx_full;

	// two restoring steps per cycle
	always_comb begin
		r1  = {rem_q, quo_q[CHUNK_W-1]};
		ge1 = (r1 >= {1'b0, len_q});
		r1s = ge1 ? LEN_W'(r1 - {1'b0, len_q}) : r1[LEN_W-1:0];
		r2  = {r1s, quo_q[CHUNK_W-2]};
		ge2 = (r2 >= {1'b0, len_q});
		r2s = ge2 ? LEN_W'(r2 - {1'b0, len_q}) : r2[LEN_W-1:0];
	end

	// remainder and previous index are both below the length: one subtract
	always_comb begin
		sum      = {1'b0, rem_q} + (LEN_W + 1)'(prev_q);
		idx_full = (sum >= {1'b0, len_q}) ? LEN_W'(sum - {1'b0, len_q})
		                                  : sum[LEN_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quo_q  <= chunk_word;
			rem_q  <= '0;
			prev_q <= '0;
			len_q  <= (list_len == '0) ? LEN_W'(1) : list_len;
			last_q <= last_chunk;
		end else if (cmd.step) begin
			quo_q <= {quo_q[CHUNK_W-3:0], ge1, ge2};
			rem_q <= r2s;
		end else if (cmd.emit) begin
			// quotient stays as the next dividend: floor of floor is floor
			rem_q  <= '0;
			prev_q <= idx_full[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			word_index_q    <= idx_full[IDX_W-1:0];
			last_of_chunk_q <= cmd.final_word;
			last_of_input_q <= cmd.final_word & last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= cmd.emit;
	end

	assign word_index    = word_index_q;
	assign last_of_chunk = last_of_chunk_q;
	assign last_of_input = last_of_input_q;
	assign valid         = valid_q;

endmodule
